// ===== hdl/sit_pkg.sv =====
// Shared types and constants of the sorted integer-key table.
// Used by the channel interfaces, the entry store, the controller and the top level.
package sit_pkg;

  localparam int DEPTH     = 256;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = $clog2(DEPTH + 2);
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 3;
  localparam int POS_OUT_W = 9;
  localparam int CNT_OUT_W = 9;

  typedef enum logic {
    FN_SET    = 1'b0,
    FN_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_REPLACED = 3'd3,
    ST_DELETED  = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef struct packed {
    logic             nothing;
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

// ===== hdl/sit_in_if.sv =====
// Request channel of the sorted integer-key table: valid/ready plus the request fields.
// Depends on sit_pkg.
interface sit_in_if;
  import sit_pkg::*;

  logic                     valid;
  logic                     ready;
  func_t                    func;
  logic signed [KEY_W-1:0]  key;
  logic [VAL_W-1:0]         write_value;
  logic                     value_is_nothing;

  modport source (output valid, func, key, write_value, value_is_nothing, input ready);
  modport sink   (input valid, func, key, write_value, value_is_nothing, output ready);
endinterface

// ===== hdl/sit_out_if.sv =====
// Result channel of the sorted integer-key table: valid/ready plus the result fields.
// Depends on sit_pkg.
interface sit_out_if;
  import sit_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [POS_OUT_W-1:0] position;
  logic [VAL_W-1:0]     read_value;
  logic                 read_is_nothing;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, status, position, read_value, read_is_nothing, entry_count,
                  input ready);
  modport sink   (input valid, status, position, read_value, read_is_nothing, entry_count,
                  output ready);
endinterface

// ===== hdl/sit_store.sv =====
// Entry store: one synchronous memory of key, value and nothing marker per entry.
// One write and one read port, registered read data. Depends on sit_pkg.
module sit_store (
  input  logic              clk,
  input  sit_pkg::mem_req_t req,
  output sit_pkg::entry_t   rd_data
);
  import sit_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== hdl/sit_ctrl.sv =====
// Controller: binary search over the entry store, then replace, delete or insert,
// moving entries one per cycle, and the output register. Depends on sit_pkg and the
// channel interfaces.
module sit_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  sit_in_if.sink                   in_ch,
  sit_out_if.source                out_ch,
  output sit_pkg::mem_req_t        mem_req,
  input  sit_pkg::entry_t          rd_data,
  output logic [sit_pkg::CNT_W-1:0] fill
);
  import sit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_t;

  state_t              state_r;
  func_t               func_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    wval_r;
  logic                wnoth_r;
  logic [POS_W-1:0]    lo_r, hi_r, mid_r, pos_r;
  logic                hit_r;
  logic [VAL_W-1:0]    rval_r;
  logic                rnoth_r;
  status_t             status_r;
  logic [CNT_W-1:0]    fill_r;
  logic [PTR_W-1:0]    src_r, pend_addr_r;
  logic [POS_W-1:0]    rem_r;
  logic                pend_r;
  logic                is_del_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [POS_OUT_W-1:0] out_pos_r;
  logic [VAL_W-1:0]     out_val_r;
  logic                 out_noth_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic [POS_W:0]   sum_w;
  logic [POS_W-1:0] mid_nxt;
  logic             key_lt, key_gt;

  assign sum_w   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_nxt = sum_w[POS_W:1];
  assign key_lt  = $signed(key_r) < $signed(rd_data.key);
  assign key_gt  = $signed(key_r) > $signed(rd_data.key);

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.position        = out_pos_r;
  assign out_ch.read_value      = out_val_r;
  assign out_ch.read_is_nothing = out_noth_r;
  assign out_ch.entry_count     = out_cnt_r;
  assign fill                   = fill_r;

  always_comb begin
    mem_req = '0;
    case (state_r)
      S_PROBE: begin
        mem_req.rd_en   = (lo_r <= hi_r);
        mem_req.rd_addr = PTR_W'(mid_nxt - POS_W'(1));
      end
      S_DECIDE: begin
        // A present key with a normal value is replaced in place.
        mem_req.wr_en   = (func_r == FN_SET) && hit_r && !wnoth_r;
        mem_req.wr_addr = PTR_W'(pos_r - POS_W'(1));
        mem_req.wr_data = '{nothing: 1'b0, value: wval_r, key: key_r};
      end
      S_SHIFT: begin
        mem_req.rd_en   = (rem_r != '0);
        mem_req.rd_addr = src_r;
        mem_req.wr_en   = pend_r;
        mem_req.wr_addr = pend_addr_r;
        mem_req.wr_data = rd_data;
      end
      S_PLACE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = PTR_W'(pos_r - POS_W'(1));
        mem_req.wr_data = '{nothing: wnoth_r, value: wval_r, key: key_r};
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_DONE the output register is either reloaded or still held.
      if (out_ch.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            func_r  <= in_ch.func;
            key_r   <= in_ch.key;
            wval_r  <= in_ch.write_value;
            wnoth_r <= in_ch.value_is_nothing;
            lo_r    <= POS_W'(1);
            hi_r    <= POS_W'(fill_r);
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo_r <= hi_r) begin
            mid_r   <= mid_nxt;
            state_r <= S_CMP;
          end else begin
            hit_r   <= 1'b0;
            pos_r   <= lo_r;
            state_r <= S_DECIDE;
          end
        end
        S_CMP: begin
          if (key_lt) begin
            hi_r    <= mid_r - POS_W'(1);
            state_r <= S_PROBE;
          end else if (key_gt) begin
            lo_r    <= mid_r + POS_W'(1);
            state_r <= S_PROBE;
          end else begin
            hit_r   <= 1'b1;
            pos_r   <= mid_r;
            rval_r  <= rd_data.value;
            rnoth_r <= rd_data.nothing;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          pend_r <= 1'b0;
          if (func_r == FN_LOOKUP) begin
            status_r <= hit_r ? ST_HIT : ST_MISS;
            state_r  <= S_DONE;
          end else if (hit_r && wnoth_r) begin
            // Delete: entries above the hit move down one place, lowest first.
            status_r <= ST_DELETED;
            src_r    <= PTR_W'(pos_r);
            rem_r    <= POS_W'(fill_r) - pos_r;
            is_del_r <= 1'b1;
            fill_r   <= fill_r - CNT_W'(1);
            state_r  <= S_SHIFT;
          end else if (hit_r) begin
            status_r <= ST_REPLACED;
            state_r  <= S_DONE;
          end else if (fill_r >= CNT_W'(DEPTH)) begin
            status_r <= ST_FULL;
            state_r  <= S_DONE;
          end else begin
            // Insert: entries from the search point up move up one place, highest first.
            status_r <= ST_INSERTED;
            src_r    <= PTR_W'(fill_r - CNT_W'(1));
            rem_r    <= POS_W'(fill_r) - pos_r + POS_W'(1);
            is_del_r <= 1'b0;
            fill_r   <= fill_r + CNT_W'(1);
            state_r  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (rem_r != '0) begin
            pend_r      <= 1'b1;
            pend_addr_r <= is_del_r ? src_r - PTR_W'(1) : src_r + PTR_W'(1);
            src_r       <= is_del_r ? src_r + PTR_W'(1) : src_r - PTR_W'(1);
            rem_r       <= rem_r - POS_W'(1);
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= is_del_r ? S_DONE : S_PLACE;
            end
          end
        end
        S_PLACE: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_pos_r    <= POS_OUT_W'(pos_r);
            out_val_r    <= (status_r == ST_HIT) ? rval_r : '0;
            out_noth_r   <= (status_r == ST_HIT) ? rnoth_r : 1'b0;
            out_cnt_r    <= CNT_OUT_W'(fill_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/sorted_int_key_table.sv =====
// Top level of the sorted integer-key table: entry store, controller and checks.
// Depends on sit_pkg, sit_in_if, sit_out_if, sit_store and sit_ctrl.
//
// Usage:
// The block keeps up to DEPTH entries (signed 32-bit key, 32-bit value, nothing
// marker) in ascending key order. Each request transaction on in_ch is a set
// (insert, replace or delete) or a lookup; each produces exactly one result
// transaction on out_ch with status, position, value and the entry count.
// Requests are taken one at a time: in_ch.ready is high only while the block is
// between requests. A request passes an accept step, binary-search probes (memory
// read, then compare), a closing step for a search that misses, a decision step
// and the load of the output register. An insert or delete also moves each affected
// entry one place, and an insert then writes the new entry, since the entry memory
// has one read and one write port and moves one entry per cycle.
// The result sits in an output register; a stalled receiver holds it there while
// the next request is already searched, and that request waits only to load it.
// A synchronous, active-low reset empties the table at once (the count is cleared,
// memory contents are left as they are) and drops any pending result.
module sorted_int_key_table (
  input  logic      clk,
  input  logic      rst_n,
  sit_in_if.sink    in_ch,
  sit_out_if.source out_ch
);
  import sit_pkg::*;

  mem_req_t         mem_req;
  entry_t           rd_data;
  logic [CNT_W-1:0] fill;

  // Entry memory: key, value and marker side by side in one word.
  sit_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Search, update sequencing and output register.
  sit_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .mem_req (mem_req),
    .rd_data (rd_data),
    .fill    (fill)
  );

  // The memory is untouched while the block waits for a request.
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !mem_req.wr_en)
    else $error("entry memory written while idle");

  // Entry moves never read and write the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
    else $error("read and write hit the same entry");

  // The entry count moves by at most one per cycle and never exceeds the depth.
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill != $past(fill)) |->
      ((fill == $past(fill) + CNT_W'(1)) || (fill == $past(fill) - CNT_W'(1))))
    else $error("entry count jumped");

  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // A refused insert is only reported when the table is really full.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_FULL)) |->
      (out_ch.entry_count == CNT_OUT_W'(DEPTH)))
    else $error("full reported below depth");

endmodule
